>>> hw/rtl/dbwu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbwu_pkg
// Request, status and kind codes and beat layout for the debug trigger unit.
// ----------------------------------------------------------------------------
package dbwu_pkg;

   localparam int ADDR_W      = 64;
   localparam int LEN_W       = 32;
   localparam int REQ_TDATA_W = 96;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [2:0] {
      REQ_ADD_BP    = 3'd0,
      REQ_REMOVE_BP = 3'd1,
      REQ_CHECK_PC  = 3'd2,
      REQ_ADD_WP    = 3'd3,
      REQ_REMOVE_WP = 3'd4,
      REQ_CHECK_ACC = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_KEPT     = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_ACCESS = 2'd2;

   localparam logic [2:0] KBIT_READ   = 3'b001;
   localparam logic [2:0] KBIT_WRITE  = 3'b010;
   localparam logic [2:0] KBIT_ACCESS = 3'b100;

endpackage : dbwu_pkg
`default_nettype wire

>>> hw/rtl/debug_breakpoint_watchpoint_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// debug_breakpoint_watchpoint_unit
// Breakpoint and watchpoint trigger tables with add, remove and check requests.
//
// Requests arrive on the req_ stream, one per beat; each gives exactly one
// response beat on the rsp_ stream carrying hit and status.
// A request beat is held in an input register; the table compare, table
// update and response are done by a single pass of parallel compare logic
// over all slots once the response register is empty or being drained,
// and the response is registered. A request thus passes through the input
// register and then the response register. Throughput is one request per
// cycle while rsp_tready is high, set by the one-pass compare and update of
// the slot tables; every request sees the table state left by the one before.
// When rsp_tready is low the response register holds, the request in the
// input register waits, and req_tready drops once that register is full.
// Reset clears all valid bits and kind bits and empties both registers;
// stored addresses and lengths are left as they were.
// ----------------------------------------------------------------------------
module debug_breakpoint_watchpoint_unit #(
   parameter int BREAKPOINT_SLOTS = 16,
   parameter int WATCH_SLOTS      = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // addr [63:0], width [95:64]
   input  wire logic [dbwu_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type [2:0], kind [4:3]
   input  wire logic [dbwu_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // hit [0], status [3:1], zero [7:4]
   output logic [dbwu_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import dbwu_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [2:0]            in_req_ff;
   logic [ADDR_W-1:0]     in_addr_ff;
   logic [LEN_W-1:0]      in_width_ff;
   logic [1:0]            in_kind_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;

   logic [BREAKPOINT_SLOTS-1:0] bp_valid_ff, bp_valid_in;
   logic [ADDR_W-1:0]           bp_address_ff [BREAKPOINT_SLOTS];
   logic [BREAKPOINT_SLOTS-1:0] bp_write;

   logic [WATCH_SLOTS-1:0]      wp_valid_ff, wp_valid_in;
   logic [ADDR_W-1:0]           wp_start_ff [WATCH_SLOTS];
   logic [LEN_W-1:0]            wp_length_ff [WATCH_SLOTS];
   logic [2:0]                  wp_kinds_ff [WATCH_SLOTS];
   logic [2:0]                  wp_kinds_in [WATCH_SLOTS];
   logic [WATCH_SLOTS-1:0]      wp_write;

   logic                  fire;
   logic                  req_accept;
   logic [LEN_W-1:0]      width_norm;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;
   assign width_norm = (in_width_ff == '0) ? LEN_W'(1) : in_width_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_status_ff, rsp_hit_ff};

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      logic [BREAKPOINT_SLOTS-1:0] bp_match;
      logic [BREAKPOINT_SLOTS-1:0] bp_free;
      logic [WATCH_SLOTS-1:0]      wp_match;
      logic [WATCH_SLOTS-1:0]      wp_free;
      logic [WATCH_SLOTS-1:0]      wp_hit;
      logic                        found;
      logic [2:0]                  kbit;
      logic [2:0]                  need;
      logic [2:0]                  sel_kinds;
      logic [2:0]                  left_kinds;
      logic [ADDR_W:0]             acc_end;
      logic [ADDR_W:0]             wp_end;
      found      = 1'b0;
      bp_match   = '0;
      bp_free    = '0;
      wp_match   = '0;
      wp_free    = '0;
      wp_hit     = '0;
      sel_kinds  = '0;
      kbit       = 3'(1 << in_kind_ff);
      need       = KBIT_ACCESS | ((in_kind_ff == KIND_WRITE) ? KBIT_WRITE : KBIT_READ);
      acc_end    = {1'b0, in_addr_ff} + (ADDR_W + 1)'(width_norm - LEN_W'(1));

      for (int i = 0; i < BREAKPOINT_SLOTS; i++) begin
         bp_match[i] = bp_valid_ff[i] && (bp_address_ff[i] == in_addr_ff);
         if (!bp_valid_ff[i] && !found) begin
            bp_free[i] = 1'b1;
            found      = 1'b1;
         end
      end
      found = 1'b0;
      for (int i = 0; i < WATCH_SLOTS; i++) begin
         wp_match[i] = wp_valid_ff[i] && (wp_start_ff[i] == in_addr_ff)
                       && (wp_length_ff[i] == width_norm);
         if (wp_match[i]) begin
            sel_kinds = sel_kinds | wp_kinds_ff[i];
         end
         if (!wp_valid_ff[i] && !found) begin
            wp_free[i] = 1'b1;
            found      = 1'b1;
         end
         wp_end    = {1'b0, wp_start_ff[i]} + (ADDR_W + 1)'(wp_length_ff[i] - LEN_W'(1));
         wp_hit[i] = wp_valid_ff[i] && ((wp_kinds_ff[i] & need) != 3'b000)
                     && ({1'b0, wp_start_ff[i]} <= acc_end)
                     && ({1'b0, in_addr_ff} <= wp_end);
      end
      left_kinds = sel_kinds & ~kbit;

      bp_valid_in   = bp_valid_ff;
      bp_write      = '0;
      wp_valid_in   = wp_valid_ff;
      wp_write      = '0;
      wp_kinds_in   = wp_kinds_ff;
      rsp_hit_in    = 1'b0;
      rsp_status_in = ST_ADDED;

      case (in_req_ff)
         REQ_ADD_BP: begin
            if (bp_match != '0) begin
               rsp_status_in = ST_PRESENT;
            end else if (bp_free == '0) begin
               rsp_status_in = ST_FULL;
            end else begin
               bp_write      = bp_free;
               bp_valid_in   = bp_valid_ff | bp_free;
               rsp_status_in = ST_ADDED;
            end
         end
         REQ_REMOVE_BP: begin
            if (bp_match != '0) begin
               bp_valid_in   = bp_valid_ff & ~bp_match;
               rsp_status_in = ST_REMOVED;
            end else begin
               rsp_status_in = ST_NOTFOUND;
            end
         end
         REQ_CHECK_PC: begin
            rsp_hit_in = (bp_match != '0);
         end
         REQ_ADD_WP: begin
            if (in_kind_ff > KIND_ACCESS) begin
               rsp_status_in = ST_NOTFOUND;
            end else if (wp_match != '0) begin
               for (int i = 0; i < WATCH_SLOTS; i++) begin
                  if (wp_match[i]) begin
                     wp_kinds_in[i] = wp_kinds_ff[i] | kbit;
                  end
               end
               rsp_status_in = ST_PRESENT;
            end else if (wp_free == '0) begin
               rsp_status_in = ST_FULL;
            end else begin
               for (int i = 0; i < WATCH_SLOTS; i++) begin
                  if (wp_free[i]) begin
                     wp_kinds_in[i] = kbit;
                  end
               end
               wp_write      = wp_free;
               wp_valid_in   = wp_valid_ff | wp_free;
               rsp_status_in = ST_ADDED;
            end
         end
         REQ_REMOVE_WP: begin
            if (in_kind_ff > KIND_ACCESS || wp_match == '0) begin
               rsp_status_in = ST_NOTFOUND;
            end else begin
               for (int i = 0; i < WATCH_SLOTS; i++) begin
                  if (wp_match[i]) begin
                     wp_kinds_in[i] = left_kinds;
                  end
               end
               if (left_kinds == 3'b000) begin
                  wp_valid_in   = wp_valid_ff & ~wp_match;
                  rsp_status_in = ST_REMOVED;
               end else begin
                  rsp_status_in = ST_KEPT;
               end
            end
         end
         REQ_CHECK_ACC: begin
            rsp_hit_in = (wp_hit != '0);
         end
         default: begin
            rsp_hit_in    = 1'b0;
            rsp_status_in = ST_ADDED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bp_valid_ff  <= '0;
         wp_valid_ff  <= '0;
         for (int i = 0; i < WATCH_SLOTS; i++) begin
            wp_kinds_ff[i] <= 3'b000;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            bp_valid_ff <= bp_valid_in;
            wp_valid_ff <= wp_valid_in;
            wp_kinds_ff <= wp_kinds_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_req_ff   <= req_tuser[2:0];
         in_kind_ff  <= req_tuser[4:3];
         in_addr_ff  <= req_tdata[ADDR_W-1:0];
         in_width_ff <= req_tdata[ADDR_W+LEN_W-1:ADDR_W];
      end
      if (fire) begin
         rsp_hit_ff    <= rsp_hit_in;
         rsp_status_ff <= rsp_status_in;
         for (int i = 0; i < BREAKPOINT_SLOTS; i++) begin
            if (bp_write[i]) begin
               bp_address_ff[i] <= in_addr_ff;
            end
         end
         for (int i = 0; i < WATCH_SLOTS; i++) begin
            if (wp_write[i]) begin
               wp_start_ff[i]  <= in_addr_ff;
               wp_length_ff[i] <= width_norm;
            end
         end
      end
   end

endmodule : debug_breakpoint_watchpoint_unit
`default_nettype wire

>>> verif/trigger_checker.sv
// ----------------------------------------------------------------------------
// trigger_checker
// Watches both streams of the debug trigger unit, keeps its own copy of the
// breakpoint and watchpoint tables, predicts hit and status for every
// accepted request and compares each response beat with the oldest one.
// ----------------------------------------------------------------------------
module trigger_checker #(
   parameter int BP_SLOTS = 16,
   parameter int WP_SLOTS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   input  wire logic                                 req_tready,
   // addr [63:0], width [95:64]
   input  wire logic [dbwu_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type [2:0], kind [4:3]
   input  wire logic [dbwu_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  wire logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // hit [0], status [3:1], zero [7:4]
   input  wire logic [dbwu_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output int                                        fail_count,
   output int                                        pending_count,
   output int                                        checked_count,
   output int                                        hit_count,
   output int                                        full_count
);
   import dbwu_pkg::*;

   typedef struct packed {
      logic       hit;
      status_type status;
   } outcome_type;

   logic        brk_used  [BP_SLOTS];
   logic [63:0] brk_pc    [BP_SLOTS];
   logic        wat_used  [WP_SLOTS];
   logic [63:0] wat_base  [WP_SLOTS];
   logic [31:0] wat_len   [WP_SLOTS];
   logic [2:0]  wat_kinds [WP_SLOTS];

   outcome_type expected_outcomes[$];

   task automatic report_mismatch(input string msg);
      if (fail_count < 40) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   // true when p lies at or below the last byte of [s, s + w - 1], end taken
   // with one extra bit so the range never wraps
   function automatic logic reaches(input logic [63:0] p, input logic [63:0] s,
                                    input logic [31:0] w);
      logic [64:0] range_end;
      range_end = {1'b0, s} + {33'd0, w - 32'd1};
      return {1'b0, p} <= range_end;
   endfunction

   function automatic outcome_type trigger_outcome(input logic [2:0]  code,
                                                   input logic [63:0] addr,
                                                   input logic [31:0] len,
                                                   input logic [1:0]  kind);
      outcome_type res;
      int          i;
      int          bp_match;
      int          bp_free;
      int          wp_match;
      int          wp_free;
      logic        acc_hit;
      logic [2:0]  need;
      logic [2:0]  kbit;
      res.hit    = 1'b0;
      res.status = ST_ADDED;
      if (len == '0) begin
         len = 32'd1;
      end
      need     = KBIT_ACCESS | ((kind == KIND_WRITE) ? KBIT_WRITE : KBIT_READ);
      kbit     = KBIT_READ << kind;
      bp_match = -1;
      bp_free  = -1;
      wp_match = -1;
      wp_free  = -1;
      acc_hit  = 1'b0;
      for (i = BP_SLOTS - 1; i >= 0; i--) begin
         if (brk_used[i] && brk_pc[i] == addr) bp_match = i;
         if (!brk_used[i]) bp_free = i;
      end
      for (i = WP_SLOTS - 1; i >= 0; i--) begin
         if (wat_used[i] && wat_base[i] == addr && wat_len[i] == len) wp_match = i;
         if (!wat_used[i]) wp_free = i;
         if (wat_used[i] && (wat_kinds[i] & need) != '0 &&
             reaches(wat_base[i], addr, len) && reaches(addr, wat_base[i], wat_len[i])) begin
            acc_hit = 1'b1;
         end
      end
      case (code)
         REQ_ADD_BP: begin
            if (bp_match >= 0) begin
               res.status = ST_PRESENT;
            end else if (bp_free >= 0) begin
               brk_used[bp_free] = 1'b1;
               brk_pc[bp_free]   = addr;
               res.status        = ST_ADDED;
            end else begin
               res.status = ST_FULL;
            end
         end
         REQ_REMOVE_BP: begin
            if (bp_match >= 0) begin
               brk_used[bp_match] = 1'b0;
               res.status         = ST_REMOVED;
            end else begin
               res.status = ST_NOTFOUND;
            end
         end
         REQ_CHECK_PC: begin
            res.hit = (bp_match >= 0);
         end
         REQ_ADD_WP: begin
            if (kind > KIND_ACCESS) begin
               res.status = ST_NOTFOUND;
            end else if (wp_match >= 0) begin
               wat_kinds[wp_match] = wat_kinds[wp_match] | kbit;
               res.status          = ST_PRESENT;
            end else if (wp_free >= 0) begin
               wat_used[wp_free]  = 1'b1;
               wat_base[wp_free]  = addr;
               wat_len[wp_free]   = len;
               wat_kinds[wp_free] = kbit;
               res.status         = ST_ADDED;
            end else begin
               res.status = ST_FULL;
            end
         end
         REQ_REMOVE_WP: begin
            if (kind > KIND_ACCESS || wp_match < 0) begin
               res.status = ST_NOTFOUND;
            end else begin
               wat_kinds[wp_match] = wat_kinds[wp_match] & ~kbit;
               if (wat_kinds[wp_match] == '0) begin
                  wat_used[wp_match] = 1'b0;
                  res.status         = ST_REMOVED;
               end else begin
                  res.status = ST_KEPT;
               end
            end
         end
         REQ_CHECK_ACC: begin
            res.hit = acc_hit;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         fail_count    = 0;
         checked_count = 0;
         hit_count     = 0;
         full_count    = 0;
         for (int i = 0; i < BP_SLOTS; i++) begin
            brk_used[i] = 1'b0;
            brk_pc[i]   = '0;
         end
         for (int i = 0; i < WP_SLOTS; i++) begin
            wat_used[i]  = 1'b0;
            wat_base[i]  = '0;
            wat_len[i]   = '0;
            wat_kinds[i] = '0;
         end
         expected_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing expected: %h", rsp_tdata));
            end else begin
               want = expected_outcomes.pop_front();
               checked_count++;
               if (rsp_tdata[0] !== want.hit) begin
                  report_mismatch($sformatf("beat %0d hit %b, expected %b",
                                            checked_count, rsp_tdata[0], want.hit));
               end
               if (rsp_tdata[3:1] !== want.status) begin
                  report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                            checked_count, rsp_tdata[3:1], want.status));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = trigger_outcome(req_tuser[2:0], req_tdata[63:0], req_tdata[95:64],
                                   req_tuser[4:3]);
            if (want.hit) hit_count++;
            if (want.status == ST_FULL) full_count++;
            expected_outcomes.push_back(want);
         end
      end
      pending_count = expected_outcomes.size();
   end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the debug trigger unit: a directed pass over the
// table corner cases, then random add/remove/check traffic drawn from small
// key pools so both tables fill, under four sender/receiver idling phases.
// ----------------------------------------------------------------------------
module tb_top;
   import dbwu_pkg::*;

   localparam logic [2:0] REQ_SPARE_LO = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;
   localparam logic [1:0] KIND_SPARE   = 2'd3;
   localparam int         PHASE_ITEMS  = 175;
   localparam int         BP_KEYS      = 24;
   localparam int         WP_KEYS      = 12;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         LONG_HOLD    = 60;
   localparam int         HOLD_AFTER   = 40;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending_count;
   int checked_count;
   int hit_count;
   int full_count;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int cycle_count   = 0;

   logic [63:0] bp_pool [BP_KEYS];
   logic [63:0] wp_base [WP_KEYS];
   logic [31:0] wp_len  [WP_KEYS];

   debug_breakpoint_watchpoint_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   trigger_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .hit_count     (hit_count),
      .full_count    (full_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     pending_count);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // response side: random stalls, and one long hold early in the unpaced phase
   initial begin
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_once && items_sent >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_beat(input logic [2:0] code, input logic [63:0] addr,
                            input logic [31:0] len, input logic [1:0] kind);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, addr};
      req_tuser  <= {kind, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_item();
      int          pick;
      int          j;
      logic [1:0]  kind;
      logic [63:0] addr;
      logic [31:0] len;
      pick = $urandom_range(99);
      j    = $urandom_range(WP_KEYS - 1);
      kind = ($urandom_range(19) == 0) ? KIND_SPARE : 2'($urandom_range(2));
      if (pick < 16) begin
         send_beat(REQ_ADD_BP, bp_pool[$urandom_range(BP_KEYS - 1)], $urandom, kind);
      end else if (pick < 26) begin
         send_beat(REQ_REMOVE_BP, bp_pool[$urandom_range(BP_KEYS - 1)], $urandom, kind);
      end else if (pick < 40) begin
         addr = ($urandom_range(4) == 0) ? rand64() : bp_pool[$urandom_range(BP_KEYS - 1)];
         send_beat(REQ_CHECK_PC, addr, $urandom, kind);
      end else if (pick < 56) begin
         send_beat(REQ_ADD_WP, wp_base[j], wp_len[j], kind);
      end else if (pick < 64) begin
         send_beat(REQ_REMOVE_WP, wp_base[j], wp_len[j], kind);
      end else if (pick < 95) begin
         addr = wp_base[j] + 64'($urandom_range(16)) - 64'd8;
         if ($urandom_range(9) == 0) addr = rand64();
         len = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(16));
         send_beat(REQ_CHECK_ACC, addr, len, kind);
      end else if (pick < 98) begin
         // keys that were never stored
         send_beat($urandom_range(1) ? REQ_ADD_WP : REQ_REMOVE_WP, rand64(), $urandom, kind);
      end else begin
         send_beat($urandom_range(1) ? REQ_SPARE_LO : REQ_SPARE_HI, rand64(), $urandom,
                   2'($urandom_range(3)));
      end
   endtask

   initial begin
      int idle_of_phase  [4];
      int stall_of_phase [4];
      idle_of_phase  = '{0, 78, 0, 34};
      stall_of_phase = '{0, 0, 78, 34};

      bp_pool[0] = '0;
      bp_pool[1] = '1;
      bp_pool[2] = 64'h8000_0000_0000_0000;
      for (int i = 3; i < BP_KEYS; i++) bp_pool[i] = rand64();
      wp_base[0] = 64'hFFFF_FFFF_FFFF_FFF0;
      wp_len[0]  = 32'hFFFF_FFFF;
      wp_base[1] = '0;
      wp_len[1]  = 32'd1;
      wp_base[2] = 64'h2000;
      wp_len[2]  = '0;
      for (int i = 3; i < WP_KEYS; i++) begin
         wp_base[i] = 64'h4000 + 64'($urandom_range(255)) * 64'd4;
         wp_len[i]  = 32'($urandom_range(1, 32));
      end
      wp_base[WP_KEYS - 1] = rand64();
      wp_len[WP_KEYS - 1]  = $urandom;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(REQ_CHECK_PC,  '0, $urandom, KIND_READ);
      send_beat(REQ_ADD_BP,    '0, $urandom, KIND_READ);
      send_beat(REQ_ADD_BP,    '1, $urandom, KIND_SPARE);
      send_beat(REQ_ADD_BP,    '0, $urandom, KIND_WRITE);
      send_beat(REQ_CHECK_PC,  '1, $urandom, KIND_READ);
      send_beat(REQ_REMOVE_BP, '1, $urandom, KIND_READ);
      send_beat(REQ_REMOVE_BP, '1, $urandom, KIND_READ);
      send_beat(REQ_ADD_WP,    64'h1000, '0, KIND_READ);
      send_beat(REQ_ADD_WP,    64'h1000, 32'd1, KIND_WRITE);
      send_beat(REQ_ADD_WP,    64'h1000, 32'd1, KIND_WRITE);
      send_beat(REQ_CHECK_ACC, 64'h1000, 32'd1, KIND_WRITE);
      send_beat(REQ_CHECK_ACC, 64'h0FFF, 32'd2, KIND_SPARE);
      send_beat(REQ_CHECK_ACC, 64'h1001, '0, KIND_READ);
      send_beat(REQ_ADD_WP,    64'hFFFF_FFFF_FFFF_FFF0, '1, KIND_ACCESS);
      send_beat(REQ_CHECK_ACC, '0, 32'd16, KIND_READ);
      send_beat(REQ_CHECK_ACC, '1, '1, KIND_WRITE);
      send_beat(REQ_REMOVE_WP, 64'h1000, 32'd1, KIND_ACCESS);
      send_beat(REQ_REMOVE_WP, 64'h1000, 32'd1, KIND_READ);
      send_beat(REQ_REMOVE_WP, 64'h1000, 32'd1, KIND_WRITE);
      send_beat(REQ_ADD_WP,    64'h3000, 32'd4, KIND_SPARE);
      send_beat(REQ_REMOVE_WP, 64'hFFFF_FFFF_FFFF_FFF0, '1, KIND_SPARE);
      send_beat(REQ_REMOVE_WP, 64'h5000, 32'd8, KIND_READ);
      send_beat(REQ_SPARE_LO,  rand64(), $urandom, KIND_SPARE);
      send_beat(REQ_SPARE_HI,  rand64(), $urandom, KIND_WRITE);
      send_beat(REQ_REMOVE_BP, '0, $urandom, KIND_READ);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_of_phase[p];
         stall_pct     = stall_of_phase[p];
         for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      end
      req_tvalid <= 1'b0;
      stall_pct = 0;

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests over 4 idling phases, checked %0d responses",
               items_sent, checked_count);
      $display("predicted %0d hits and %0d table-full replies", hit_count, full_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/dbwu_pkg.sv
hw/rtl/debug_breakpoint_watchpoint_unit.sv
verif/trigger_checker.sv
verif/tb_top.sv
